/* sv/tsop_pkg.sv */
// Shared types and constants for the TCP timestamp option parser.
package tsop_pkg;

  localparam int MAX_OPTIONS_SCANNED = 11;
  localparam int MAX_OPTION_AREA     = 40;

  localparam int OPT_CNT_W  = $clog2(MAX_OPTIONS_SCANNED + 1);
  localparam int BODY_CNT_W = $clog2(MAX_OPTION_AREA + 1);

  // parse phases
  localparam logic [1:0] PH_KIND = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  localparam logic [7:0] KIND_END = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_TS  = 8'd8;
  localparam logic [7:0] LEN_TS   = 8'd10;
  localparam logic [7:0] LEN_MIN  = 8'd2;
  localparam logic [7:0] LEN_MAX  = 8'(MAX_OPTION_AREA + 2);

  // bytes left in a timestamp body once TSval has been collected (the TSecr bytes)
  localparam logic [BODY_CNT_W-1:0] TSECR_BYTES = BODY_CNT_W'(4);

  typedef struct packed {
    logic [7:0] option_byte;
    logic       byte_present;
    logic       last_of_area;
  } tsop_in_t;

  typedef struct packed {
    logic [1:0]  parse_status;
    logic [31:0] sender_timestamp;
    logic [31:0] echoed_timestamp;
  } tsop_out_t;

  typedef struct packed {
    logic [1:0]            phase;
    logic [BODY_CNT_W-1:0] bytes_left;
    logic [OPT_CNT_W-1:0]  opt_count;
    logic                  in_ts;
    logic [31:0]           tsval;
    logic [31:0]           tsecr;
    logic [1:0]            status;
  } tsop_state_t;

  localparam tsop_state_t STATE_CLEAR = '{
    phase:      PH_KIND,
    bytes_left: '0,
    opt_count:  '0,
    in_ts:      1'b0,
    tsval:      32'd0,
    tsecr:      32'd0,
    status:     ST_NOT_FOUND
  };

endpackage

/* sv/tsop_step.sv */
// Combinational parse step: one option byte against the current scan state.
module tsop_step (
  input  tsop_pkg::tsop_state_t state,
  input  tsop_pkg::tsop_in_t    item,
  output tsop_pkg::tsop_state_t state_next,
  output logic                  emit,
  output tsop_pkg::tsop_out_t   result
);

  tsop_pkg::tsop_state_t after;   // state once the byte is taken
  tsop_pkg::tsop_state_t fin;     // state the result is formed from
  logic [tsop_pkg::OPT_CNT_W-1:0] cnt_inc;
  logic [tsop_pkg::BODY_CNT_W-1:0] left_dec;
  logic [1:0] st;

  always_comb begin
    after    = state;
    cnt_inc  = state.opt_count + tsop_pkg::OPT_CNT_W'(1);
    left_dec = state.bytes_left - tsop_pkg::BODY_CNT_W'(1);
    case (state.phase)
      tsop_pkg::PH_KIND: begin
        if (item.option_byte == tsop_pkg::KIND_END) begin
          after.status = tsop_pkg::ST_NOT_FOUND;
          after.phase  = tsop_pkg::PH_DONE;
        end else if (item.option_byte == tsop_pkg::KIND_NOP) begin
          after.opt_count = cnt_inc;
          after.phase = (32'(cnt_inc) >= tsop_pkg::MAX_OPTIONS_SCANNED) ?
                        tsop_pkg::PH_DONE : tsop_pkg::PH_KIND;
        end else begin
          after.in_ts = (item.option_byte == tsop_pkg::KIND_TS);
          after.phase = tsop_pkg::PH_LEN;
        end
      end
      tsop_pkg::PH_LEN: begin
        if (item.option_byte < tsop_pkg::LEN_MIN ||
            item.option_byte > tsop_pkg::LEN_MAX) begin
          after.status = tsop_pkg::ST_MALFORMED;
          after.phase  = tsop_pkg::PH_DONE;
        end else begin
          if (item.option_byte != tsop_pkg::LEN_TS) after.in_ts = 1'b0;
          after.bytes_left = tsop_pkg::BODY_CNT_W'(item.option_byte - tsop_pkg::LEN_MIN);
          if (item.option_byte == tsop_pkg::LEN_MIN) begin
            after.opt_count = cnt_inc;
            after.phase = (32'(cnt_inc) >= tsop_pkg::MAX_OPTIONS_SCANNED) ?
                          tsop_pkg::PH_DONE : tsop_pkg::PH_KIND;
          end else begin
            after.phase = tsop_pkg::PH_BODY;
          end
        end
      end
      tsop_pkg::PH_BODY: begin
        if (state.in_ts) begin
          if (state.bytes_left > tsop_pkg::TSECR_BYTES)
            after.tsval = {state.tsval[23:0], item.option_byte};
          else
            after.tsecr = {state.tsecr[23:0], item.option_byte};
        end
        after.bytes_left = left_dec;
        if (left_dec == '0) begin
          if (state.in_ts) begin
            after.status = tsop_pkg::ST_FOUND;
            after.phase  = tsop_pkg::PH_DONE;
          end else begin
            after.opt_count = cnt_inc;
            after.phase = (32'(cnt_inc) >= tsop_pkg::MAX_OPTIONS_SCANNED) ?
                          tsop_pkg::PH_DONE : tsop_pkg::PH_KIND;
          end
        end
      end
      default: begin
        after = state;
      end
    endcase

    // an empty-area item ends the packet without taking the byte
    fin  = item.byte_present ? after : state;
    emit = !item.byte_present || item.last_of_area;
    st   = (fin.phase == tsop_pkg::PH_KIND || fin.phase == tsop_pkg::PH_DONE) ?
           fin.status : tsop_pkg::ST_MALFORMED;
    result.parse_status     = st;
    result.sender_timestamp = (st == tsop_pkg::ST_FOUND) ? fin.tsval : 32'd0;
    result.echoed_timestamp = (st == tsop_pkg::ST_FOUND) ? fin.tsecr : 32'd0;
    state_next = emit ? tsop_pkg::STATE_CLEAR : after;
  end

endmodule

/* sv/tcp_timestamp_option_parser.sv */
// Top level of the TCP timestamp option parser: scan state and result buffer.
//
// Feed the option area of each TCP header one byte per item, with
// last_of_area on the final byte, or a single item with byte_present low
// for an empty area (or to close an area early). The parser walks the
// kind/length options and, at the end of each area, delivers one result:
// found with TSval/TSecr, not found, or malformed. The scan state is updated
// by one short step of logic, so one item is taken every clock while
// item_stall is low. The result of the item that ends its area is registered
// in an output register, or in a one-entry skid register when the output
// register is occupied and stalled, so bytes keep flowing while a result waits;
// item_stall rises only when both hold a result that has not been taken.
module tcp_timestamp_option_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  tsop_pkg::tsop_in_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output tsop_pkg::tsop_out_t result
);

  tsop_pkg::tsop_state_t state;
  tsop_pkg::tsop_state_t state_next;
  tsop_pkg::tsop_out_t   step_result;
  tsop_pkg::tsop_out_t   skid;
  logic                  step_emit;
  logic                  skid_valid;
  logic                  take;
  logic                  drain;

  tsop_step u_step (
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .emit       (step_emit),
    .result     (step_result)
  );

  // hold off input only when both result slots are full
  assign item_stall = skid_valid;
  assign take       = item_valid && !item_stall;
  assign drain      = result_valid && !result_stall;

  // advance scan state on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsop_pkg::STATE_CLEAR;
    end else if (take) begin
      state <= state_next;
    end
  end

  // output register plus skid; a new result goes to the skid only when
  // the output register is occupied and stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (drain) begin
        if (skid_valid) begin
          result_valid <= 1'b1;
          skid_valid   <= 1'b0;
        end else if (take && step_emit) begin
          result_valid <= 1'b1;
        end else begin
          result_valid <= 1'b0;
        end
      end else if (take && step_emit) begin
        if (result_valid) begin
          skid_valid <= 1'b1;
        end else begin
          result_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain && skid_valid) begin
      result <= skid;
    end else if (take && step_emit && (drain || !result_valid)) begin
      result <= step_result;
    end
    if (take && step_emit && result_valid && !drain) begin
      skid <= step_result;
    end
  end

`ifndef SYNTHESIS
  // the skid only ever fills behind an occupied output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid holds a result while output register is empty");

  // timestamps are zero unless the status says found
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.parse_status != tsop_pkg::ST_FOUND) |->
    (result.sender_timestamp == 32'd0 && result.echoed_timestamp == 32'd0))
    else $error("nonzero timestamp on a result that is not found");

  // the option counter never passes the scan limit
  assert property (@(posedge clk) disable iff (rst)
    32'(state.opt_count) <= tsop_pkg::MAX_OPTIONS_SCANNED)
    else $error("option count exceeds scan limit");

  // an item that ends an area leaves a fresh scan state
  assert property (@(posedge clk) disable iff (rst)
    (take && (!item.byte_present || item.last_of_area)) |=>
    (state == tsop_pkg::STATE_CLEAR))
    else $error("scan state not cleared after end of area");
`endif

endmodule

/* bench/tb.sv */
// Self-checking testbench for the TCP timestamp option parser.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsop_pkg::*;

  // Receiver hold-off long enough to back the parser up into its input.
  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 450;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  tsop_in_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  tsop_out_t result;

  tcp_timestamp_option_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One row of the directed table. When "given" is set the row closes an
  // option area and its result is typed in; otherwise the scanner decides.
  typedef struct packed {
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        given;
    logic [1:0]  status;
    logic [31:0] tsval;
    logic [31:0] tsecr;
  } row_t;

  localparam row_t DIRECTED [24] = '{
    // empty option area on a fresh packet
    '{8'h5A,     1'b0, 1'b0, 1'b1, ST_NOT_FOUND, 32'd0,        32'd0},
    // end-of-list kind as the only byte
    '{KIND_END,  1'b1, 1'b1, 1'b1, ST_NOT_FOUND, 32'd0,        32'd0},
    // timestamp with all-ones TSval and all-zeros TSecr
    '{KIND_TS,   1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{LEN_TS,    1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'hFF,     1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'hFF,     1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'hFF,     1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'hFF,     1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'h00,     1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'h00,     1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'h00,     1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'h00,     1'b1, 1'b1, 1'b1, ST_FOUND,     32'hFFFFFFFF, 32'd0},
    // length byte below the minimum
    '{8'd5,      1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'd1,      1'b1, 1'b1, 1'b1, ST_MALFORMED, 32'd0,        32'd0},
    // length one past the largest body that fits
    '{8'd2,      1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{LEN_MAX + 8'd1, 1'b1, 1'b1, 1'b1, ST_MALFORMED, 32'd0,   32'd0},
    // area ends right after a kind that needs a length
    '{8'd3,      1'b1, 1'b1, 1'b1, ST_MALFORMED, 32'd0,        32'd0},
    // pad, then an empty-area item closes the packet cleanly
    '{KIND_NOP,  1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'hA5,     1'b0, 1'b1, 1'b1, ST_NOT_FOUND, 32'd0,        32'd0},
    // option with no body
    '{8'd4,      1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{LEN_MIN,   1'b1, 1'b1, 1'b1, ST_NOT_FOUND, 32'd0,        32'd0},
    // area ends inside a timestamp body
    '{KIND_TS,   1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{LEN_TS,    1'b1, 1'b0, 1'b0, ST_NOT_FOUND, 32'd0,        32'd0},
    '{8'h12,     1'b1, 1'b1, 1'b1, ST_MALFORMED, 32'd0,        32'd0}
  };

  // Results still owed by the parser, oldest first.
  tsop_out_t ts_results_due[$];
  int        errors        = 0;
  int        items_sent    = 0;
  bit        calm          = 1'b0;
  bit        hold_request  = 1'b0;
  tsop_in_t  area_q[$];

  // ---------------------------------------------------------------------
  // Option scanner: our own copy of the parse state, advanced per item.
  // ---------------------------------------------------------------------
  logic [1:0]  scan_phase;
  int          scan_left;
  int          scan_opts;
  bit          scan_in_ts;
  logic [31:0] scan_tsval;
  logic [31:0] scan_tsecr;
  logic [1:0]  scan_status;

  task automatic scan_clear();
    scan_phase  = PH_KIND;
    scan_left   = 0;
    scan_opts   = 0;
    scan_in_ts  = 1'b0;
    scan_tsval  = 32'd0;
    scan_tsecr  = 32'd0;
    scan_status = ST_NOT_FOUND;
  endtask

  // Count a finished option; past the limit the rest of the area is ignored.
  task automatic scan_option_done();
    scan_opts++;
    scan_phase = (scan_opts >= MAX_OPTIONS_SCANNED) ? PH_DONE : PH_KIND;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    case (scan_phase)
      PH_KIND: begin
        if (b == KIND_END) begin
          scan_status = ST_NOT_FOUND;
          scan_phase  = PH_DONE;
        end else if (b == KIND_NOP) begin
          scan_option_done();
        end else begin
          scan_in_ts = (b == KIND_TS);
          scan_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        // The length counts kind and length bytes; the body must fit the area.
        if (b < LEN_MIN || b > LEN_MAX) begin
          scan_status = ST_MALFORMED;
          scan_phase  = PH_DONE;
        end else begin
          if (b != LEN_TS) scan_in_ts = 1'b0;
          scan_left = int'(b) - int'(LEN_MIN);
          if (scan_left == 0) scan_option_done();
          else scan_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        // Big-endian: TSval takes the first four body bytes, TSecr the rest.
        if (scan_in_ts) begin
          if (scan_left > int'(TSECR_BYTES)) scan_tsval = {scan_tsval[23:0], b};
          else scan_tsecr = {scan_tsecr[23:0], b};
        end
        scan_left--;
        if (scan_left == 0) begin
          if (scan_in_ts) begin
            scan_status = ST_FOUND;
            scan_phase  = PH_DONE;
          end else begin
            scan_option_done();
          end
        end
      end
      default: ;
    endcase
  endtask

  // Close the area: anything mid-option is malformed; timestamps only on found.
  task automatic scan_close(output tsop_out_t r);
    logic [1:0] st;
    st = (scan_phase == PH_KIND || scan_phase == PH_DONE) ? scan_status : ST_MALFORMED;
    r.parse_status     = st;
    r.sender_timestamp = (st == ST_FOUND) ? scan_tsval : 32'd0;
    r.echoed_timestamp = (st == ST_FOUND) ? scan_tsecr : 32'd0;
    scan_clear();
  endtask

  task automatic scan_item(input tsop_in_t it, output bit made, output tsop_out_t r);
    made = 1'b0;
    r    = '0;
    // An empty-area item ends the packet without consuming a byte.
    if (!it.byte_present) begin
      scan_close(r);
      made = 1'b1;
      return;
    end
    scan_byte(it.option_byte);
    if (it.last_of_area) begin
      scan_close(r);
      made = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic tsop_in_t mk(input logic [7:0] b, input logic p, input logic l);
    tsop_in_t it;
    it.option_byte  = b;
    it.byte_present = p;
    it.last_of_area = l;
    return it;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one item, hold it until accepted, then predict what it causes.
  // Called right after a rising edge; valid stays high across back-to-back items.
  task automatic send_item(input tsop_in_t it, input bit given, input tsop_out_t want);
    int        gap;
    bit        made;
    tsop_out_t r;
    gap = idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    // Stall sampled here is the value the edge just acted on.
    do @(posedge clk); while (item_stall);
    items_sent++;
    scan_item(it, made, r);
    if (made) begin
      ts_results_due.push_back(given ? want : r);
    end
  endtask

  // Sender pause: drop valid and wait for every owed result.
  task automatic drain();
    item_valid <= 1'b0;
    wait (ts_results_due.size() == 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] other_kind();
    logic [7:0] k;
    k = 8'($urandom_range(2, 255));
    if (k == KIND_TS) k = KIND_TS + 8'd1;
    return k;
  endfunction

  // Build one option area into area_q: mostly well-formed option lists with
  // random content, plus truncation, trailing junk and plain noise.
  task automatic build_area();
    logic [7:0] body[$];
    int         nopts, len, r, cut;
    bit         empty_end;
    area_q.delete();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // noise: any mix of bytes, empty-area items and ends
      repeat ($urandom_range(1, 12))
        area_q.push_back(mk(8'($urandom), $urandom_range(0, 9) != 0,
                            $urandom_range(0, 5) == 0));
      return;
    end
    // pad-heavy lists run into the option limit
    nopts = (r < 25) ? $urandom_range(9, 14) : $urandom_range(0, 5);
    repeat (nopts) begin
      r = $urandom_range(0, 99);
      if (r < 30 || (nopts > 8 && r < 75)) begin
        body.push_back(KIND_NOP);
      end else if (r < 33) begin
        body.push_back(KIND_END);
      end else if (r < 55) begin
        body.push_back(KIND_TS);
        body.push_back(LEN_TS);
        repeat (8) body.push_back(8'($urandom));
      end else if (r < 60) begin
        // kind 8 with the wrong length is just another option
        len = $urandom_range(2, 12);
        if (len == int'(LEN_TS)) len++;
        body.push_back(KIND_TS);
        body.push_back(8'(len));
        repeat (len - 2) body.push_back(8'($urandom));
      end else if (r < 65) begin
        body.push_back(8'($urandom_range(2, 255)));
        len = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                   : $urandom_range(int'(LEN_MAX) + 1, 255);
        body.push_back(8'(len));
      end else if (r < 68) begin
        // the longest body that still fits
        body.push_back(other_kind());
        body.push_back(LEN_MAX);
        repeat (int'(LEN_MAX) - 2) body.push_back(8'($urandom));
      end else begin
        len = $urandom_range(2, 12);
        body.push_back(other_kind());
        body.push_back(8'(len));
        repeat (len - 2) body.push_back(8'($urandom));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 12 && body.size() > 1) begin
      cut = $urandom_range(1, body.size() - 1);
      while (body.size() > cut) void'(body.pop_back());
    end else if (r < 20) begin
      repeat ($urandom_range(1, 5)) body.push_back(8'($urandom));
    end
    empty_end = (body.size() == 0) || (r >= 20 && r < 30);
    foreach (body[i])
      area_q.push_back(mk(body[i], 1'b1, !empty_end && i == body.size() - 1));
    if (empty_end) area_q.push_back(mk(8'($urandom), 1'b0, 1'($urandom_range(0, 1))));
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, and one long hold on request.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int run;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        run = HOLD_CYCLES;
      end
      if (run > 0) begin
        result_stall <= 1'b1;
        run--;
      end else begin
        result_stall <= 1'b0;
        run = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest owed one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    tsop_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (ts_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d tsval %h tsecr %h",
                 $time, result.parse_status, result.sender_timestamp,
                 result.echoed_timestamp);
        errors++;
      end else begin
        want = ts_results_due.pop_front();
        if (result.parse_status !== want.parse_status) begin
          $display("%0t: parse_status expected %0d, got %0d",
                   $time, want.parse_status, result.parse_status);
          errors++;
        end
        if (result.sender_timestamp !== want.sender_timestamp) begin
          $display("%0t: sender_timestamp expected %h, got %h",
                   $time, want.sender_timestamp, result.sender_timestamp);
          errors++;
        end
        if (result.echoed_timestamp !== want.echoed_timestamp) begin
          $display("%0t: echoed_timestamp expected %h, got %h",
                   $time, want.echoed_timestamp, result.echoed_timestamp);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    tsop_out_t want;
    int        pkt;
    scan_clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (DIRECTED[i]) begin
      want.parse_status     = DIRECTED[i].status;
      want.sender_timestamp = DIRECTED[i].tsval;
      want.echoed_timestamp = DIRECTED[i].tsecr;
      send_item(mk(DIRECTED[i].data, DIRECTED[i].present, DIRECTED[i].last),
                DIRECTED[i].given, want);
    end

    // Random option areas until enough items have gone through.
    items_sent = 0;
    pkt = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (pkt == 6 || pkt == 30) drain();
      if (pkt == 12) begin
        // Hold the receiver and keep firing empty areas: one result each,
        // so the output buffer fills and the parser must stall its input.
        hold_request = 1'b1;
        calm = 1'b1;
        repeat (10) send_item(mk(8'($urandom), 1'b0, 1'($urandom_range(0, 1))), 1'b0, '0);
      end
      // A stretch with no idling on either side.
      calm = (pkt >= 18 && pkt < 23);
      build_area();
      foreach (area_q[i]) send_item(area_q[i], 1'b0, '0);
      pkt++;
    end
    calm = 1'b0;
    item_valid <= 1'b0;

    // Let every owed result arrive, then a little slack for strays.
    wait (ts_results_due.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
sv/tsop_pkg.sv
sv/tsop_step.sv
sv/tcp_timestamp_option_parser.sv
bench/tb.sv
